[sv/icmpx_pkg.sv]
// types and constants for the icmp extension / mpls label stack parser
// no deps; imported by icmp_extension_mpls_parser_top, icmpx_record_checker, tb_top
`timescale 1ns / 1ps

package icmpx_pkg;

   // final status codes
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_VERSION   = 3'd1,
      ST_CHECKSUM  = 3'd2,
      ST_SHORT     = 3'd3,
      ST_OVERRUN   = 3'd4,
      ST_UNALIGNED = 3'd5,
      ST_TRAILING  = 3'd6
   } status_type;

   // csr register indexes (byte address / 4)
   localparam logic [1:0] REG_VERSION = 2'd0;
   localparam logic [1:0] REG_CLASS   = 2'd1;
   localparam logic [1:0] REG_CTYPE   = 2'd2;

   localparam int CSR_ADDR_W = 4;
   localparam int HDR_BYTES  = 4;

   localparam logic [3:0] VERSION_RST = 4'd2;
   localparam logic [7:0] CLASS_RST   = 8'd1;
   localparam logic [7:0] CTYPE_RST   = 8'd1;

   localparam logic [15:0] CSUM_GOOD = 16'hffff;

   // result queue
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;
   localparam int Q_CNT_W = 3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  obj_class;
      logic [7:0]  obj_ctype;
      logic [13:0] word_index;
      logic [31:0] word_value;
      logic        is_mpls;
      logic [19:0] label;
      logic [2:0]  exp_bits;
      logic        bottom_flag;
      logic [7:0]  ttl;
      logic [2:0]  status;
      logic        last;
   } rsp_type;

endpackage

[sv/icmp_extension_mpls_parser_top.sv]
// channel   | direction | handshake           | payload
// req       | in        | req_valid/req_stall | icmpx_pkg::req_type (one byte + last flag)
// rsp       | out       | rsp_valid/rsp_stall | icmpx_pkg::rsp_type (word or status record)
// csr       | in/out    | apb, pready tied 1  | 32-bit registers at 0x0, 0x4, 0x8
//
// one byte per cycle while req_stall is low: each accepted byte updates the parse state
// in the same cycle and pushes zero, one or two records into a 4-entry result queue.
// records leave the queue one per cycle while rsp_stall is low; req_stall rises when
// fewer than two queue slots are free, so a stalled rsp side backs up into req once
// three records are waiting.
// reset (synchronous) clears the parse state, the queue and the csr registers.
// depends on icmpx_pkg
`timescale 1ns / 1ps

module icmp_extension_mpls_parser_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  icmpx_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output icmpx_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [icmpx_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   import icmpx_pkg::*;

   function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      begin
         s = {1'b0, a} + {1'b0, b};
         // one end-around carry is enough: the folded value never carries again
         fold_add = s[15:0] + {15'd0, s[16]};
      end
   endfunction

   // configuration registers
   logic [3:0] exp_ver_ff;
   logic [7:0] mpls_class_ff;
   logic [7:0] mpls_ctype_ff;
   logic       csr_wr;

   // parse state
   logic [2:0]  hdr_cnt_ff,    hdr_cnt_in;
   logic        csum_nz_ff,    csum_nz_in;
   logic        ver_bad_ff,    ver_bad_in;
   logic [15:0] csum_ff,       csum_in;
   logic [8:0]  hold_ff,       hold_in;
   logic [15:0] obj_len_ff,    obj_len_in;
   logic [15:0] obj_off_ff,    obj_off_in;
   logic [7:0]  cur_class_ff,  cur_class_in;
   logic [7:0]  cur_ctype_ff,  cur_ctype_in;
   logic [31:0] shift_ff,      shift_in;
   logic [13:0] word_cnt_ff,   word_cnt_in;
   status_type  err_ff,        err_in;

   // result queue
   rsp_type              q_mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   q_rd_ff, q_rd_in;
   logic [Q_PTR_W-1:0]   q_wr_ff, q_wr_in;
   logic [Q_CNT_W-1:0]   q_cnt_ff, q_cnt_in;

   logic        req_acc;
   logic        rsp_acc;
   logic        emit_word;
   logic        emit_stat;
   logic        is_mpls;
   logic        unaligned;
   logic [15:0] off_inc;
   logic [15:0] csum_fin;
   status_type  stat;
   rsp_type     word_rec;
   rsp_type     stat_rec;
   logic [7:0]  b;

   assign req_acc   = req_valid && !req_stall;
   assign rsp_acc   = rsp_valid && !rsp_stall;
   assign req_stall = q_cnt_ff > Q_CNT_W'(Q_DEPTH - 2);
   assign rsp_valid = q_cnt_ff != '0;
   assign rsp_data  = q_mem_ff[q_rd_ff];

   // csr port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[3:2])
         REG_VERSION: csr_prdata = {28'd0, exp_ver_ff};
         REG_CLASS:   csr_prdata = {24'd0, mpls_class_ff};
         REG_CTYPE:   csr_prdata = {24'd0, mpls_ctype_ff};
         default:     csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ver_ff    <= VERSION_RST;
         mpls_class_ff <= CLASS_RST;
         mpls_ctype_ff <= CTYPE_RST;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_VERSION: exp_ver_ff    <= csr_pwdata[3:0];
            REG_CLASS:   mpls_class_ff <= csr_pwdata[7:0];
            REG_CTYPE:   mpls_ctype_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // per-byte parse step
   always_comb begin
      b            = req_data.data_byte;
      hdr_cnt_in   = hdr_cnt_ff;
      csum_nz_in   = csum_nz_ff;
      ver_bad_in   = ver_bad_ff;
      csum_in      = csum_ff;
      hold_in      = hold_ff;
      obj_len_in   = obj_len_ff;
      obj_off_in   = obj_off_ff;
      cur_class_in = cur_class_ff;
      cur_ctype_in = cur_ctype_ff;
      shift_in     = shift_ff;
      word_cnt_in  = word_cnt_ff;
      err_in       = err_ff;
      emit_word    = 1'b0;
      unaligned    = obj_len_ff[1:0] != 2'd0;
      off_inc      = obj_off_ff + 16'd1;

      // checksum runs over every byte
      if (hold_ff[8]) begin
         csum_in = fold_add(csum_ff, {hold_ff[7:0], b});
         hold_in = 9'd0;
      end else begin
         hold_in = {1'b1, b};
      end

      if (hdr_cnt_ff < 3'(HDR_BYTES)) begin
         if (hdr_cnt_ff == 3'd0)
            ver_bad_in = b[7:4] != exp_ver_ff;
         else if (hdr_cnt_ff >= 3'd2 && b != 8'd0)
            csum_nz_in = 1'b1;
         hdr_cnt_in = hdr_cnt_ff + 3'd1;
      end else if (err_ff == ST_OK && !ver_bad_ff) begin
         if (obj_off_ff < 16'd4) begin
            case (obj_off_ff[1:0])
               2'd0:    obj_len_in   = {b, 8'd0};
               2'd1:    obj_len_in   = {obj_len_ff[15:8], b};
               2'd2:    cur_class_in = b;
               default: cur_ctype_in = b;
            endcase
            obj_off_in = off_inc;
            if (obj_off_ff[1:0] == 2'd3) begin
               word_cnt_in = 14'd0;
               if (obj_len_ff < 16'd4)
                  err_in = ST_SHORT;
               else if (obj_len_ff == 16'd4)
                  obj_off_in = 16'd0;
            end
         end else begin
            shift_in   = {shift_ff[23:0], b};
            obj_off_in = off_inc;
            if (!unaligned && obj_off_ff[1:0] == 2'd3) begin
               emit_word   = 1'b1;
               word_cnt_in = word_cnt_ff + 14'd1;
            end
            if (off_inc == obj_len_ff) begin
               if (unaligned) begin
                  err_in = ST_UNALIGNED;
               end else begin
                  obj_off_in  = 16'd0;
                  word_cnt_in = 14'd0;
               end
            end
         end
      end

      // status from the state after this byte
      csum_fin = hold_in[8] ? fold_add(csum_in, {hold_in[7:0], 8'd0}) : csum_in;
      if (ver_bad_in)
         stat = ST_VERSION;
      else if (csum_nz_in && csum_fin != CSUM_GOOD)
         stat = ST_CHECKSUM;
      else if (err_in != ST_OK)
         stat = err_in;
      else if (hdr_cnt_in < 3'(HDR_BYTES))
         stat = ST_OVERRUN;
      else if (obj_off_in == 16'd0)
         stat = ST_OK;
      else if (obj_off_in < 16'd4)
         stat = ST_TRAILING;
      else
         stat = ST_OVERRUN;
      emit_stat = req_data.last_byte;

      is_mpls = cur_class_ff == mpls_class_ff && cur_ctype_ff == mpls_ctype_ff;
      word_rec             = '0;
      word_rec.obj_class   = cur_class_ff;
      word_rec.obj_ctype   = cur_ctype_ff;
      word_rec.word_index  = word_cnt_ff;
      word_rec.word_value  = shift_in;
      word_rec.is_mpls     = is_mpls;
      word_rec.label       = is_mpls ? shift_in[31:12] : 20'd0;
      word_rec.exp_bits    = is_mpls ? shift_in[11:9] : 3'd0;
      word_rec.bottom_flag = is_mpls ? shift_in[8] : 1'b0;
      word_rec.ttl         = is_mpls ? shift_in[7:0] : 8'd0;

      stat_rec        = '0;
      stat_rec.kind   = 1'b1;
      stat_rec.status = stat;
      stat_rec.last   = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cnt_ff   <= '0;
         csum_nz_ff   <= 1'b0;
         ver_bad_ff   <= 1'b0;
         csum_ff      <= '0;
         hold_ff      <= '0;
         obj_len_ff   <= '0;
         obj_off_ff   <= '0;
         cur_class_ff <= '0;
         cur_ctype_ff <= '0;
         shift_ff     <= '0;
         word_cnt_ff  <= '0;
         err_ff       <= ST_OK;
      end else if (req_acc) begin
         if (req_data.last_byte) begin
            // end of area: back to the start, registers kept
            hdr_cnt_ff   <= '0;
            csum_nz_ff   <= 1'b0;
            ver_bad_ff   <= 1'b0;
            csum_ff      <= '0;
            hold_ff      <= '0;
            obj_len_ff   <= '0;
            obj_off_ff   <= '0;
            cur_class_ff <= '0;
            cur_ctype_ff <= '0;
            shift_ff     <= '0;
            word_cnt_ff  <= '0;
            err_ff       <= ST_OK;
         end else begin
            hdr_cnt_ff   <= hdr_cnt_in;
            csum_nz_ff   <= csum_nz_in;
            ver_bad_ff   <= ver_bad_in;
            csum_ff      <= csum_in;
            hold_ff      <= hold_in;
            obj_len_ff   <= obj_len_in;
            obj_off_ff   <= obj_off_in;
            cur_class_ff <= cur_class_in;
            cur_ctype_ff <= cur_ctype_in;
            shift_ff     <= shift_in;
            word_cnt_ff  <= word_cnt_in;
            err_ff       <= err_in;
         end
      end
   end

   // result queue: up to two pushes (word then status) and one pop per cycle
   always_comb begin
      q_wr_in  = q_wr_ff;
      q_rd_in  = q_rd_ff;
      q_cnt_in = q_cnt_ff;
      if (req_acc)
         q_wr_in = q_wr_ff + Q_PTR_W'(emit_word) + Q_PTR_W'(emit_stat);
      if (rsp_acc)
         q_rd_in = q_rd_ff + Q_PTR_W'(1);
      q_cnt_in = q_cnt_ff
         + (req_acc ? Q_CNT_W'(emit_word) + Q_CNT_W'(emit_stat) : Q_CNT_W'(0))
         - Q_CNT_W'(rsp_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
      end else begin
         q_wr_ff  <= q_wr_in;
         q_rd_ff  <= q_rd_in;
         q_cnt_ff <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         if (emit_word) begin
            q_mem_ff[q_wr_ff] <= word_rec;
            if (emit_stat)
               q_mem_ff[q_wr_ff + Q_PTR_W'(1)] <= stat_rec;
         end else if (emit_stat) begin
            q_mem_ff[q_wr_ff] <= stat_rec;
         end
      end
   end

   // checks
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("result queue count beyond depth");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_data.last_byte |=> hdr_cnt_ff == 3'd0 && obj_off_ff == 16'd0)
      else $error("parse state not cleared after last byte");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_data.last_byte |=> rsp_valid)
      else $error("no record pending after last byte");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> q_cnt_ff <= Q_CNT_W'(Q_DEPTH - 2))
      else $error("byte taken without room for two records");

endmodule

[verif/icmpx_record_checker.sv]
// record checker for the icmp extension / mpls label stack parser: follows the
// csr writes and the req and rsp channels, predicts every record and compares
// depends on icmpx_pkg
`timescale 1ns / 1ps

module icmpx_record_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  icmpx_pkg::req_type               req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  icmpx_pkg::rsp_type               rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic                             csr_pready,
   input  logic [icmpx_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output int                               fail_count,
   output int                               pending_count
);
   import icmpx_pkg::*;

   localparam logic KIND_WORD   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;
   localparam int   OBJ_HDR     = 4;

   // register copies
   logic [3:0]  ver_cfg;
   logic [7:0]  class_cfg;
   logic [7:0]  ctype_cfg;

   // parse state
   logic [2:0]  hdr_cnt;
   logic        csum_nz;
   logic        ver_bad;
   logic [15:0] csum;
   logic [8:0]  hold;
   logic [15:0] obj_len;
   logic [15:0] obj_off;
   logic [7:0]  cur_class;
   logic [7:0]  cur_ctype;
   logic [31:0] shreg;
   logic [13:0] word_cnt;
   status_type  err;

   rsp_type     expected_records[$];

   function automatic logic [15:0] fold16(input logic [31:0] x);
      logic [31:0] s;
      s = {16'h0, x[15:0]} + {16'h0, x[31:16]};
      s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
      return s[15:0];
   endfunction

   task automatic clear_parse();
      hdr_cnt = '0; csum_nz = 1'b0; ver_bad = 1'b0; csum = '0; hold = '0;
      obj_len = '0; obj_off = '0; cur_class = '0; cur_ctype = '0;
      shreg = '0; word_cnt = '0; err = ST_OK;
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   // one accepted byte: update the parse state and queue the records it causes
   task automatic parse_byte(input logic [7:0] b, input logic lb);
      rsp_type     rec;
      logic [15:0] off;
      logic [15:0] s;
      logic        mpls;
      status_type  st;
      if (hold[8]) begin
         csum = fold16({16'h0, csum} + {16'h0, hold[7:0], b});
         hold = '0;
      end else begin
         hold = {1'b1, b};
      end

      if (hdr_cnt < HDR_BYTES) begin
         if (hdr_cnt == 0) ver_bad = (b[7:4] != ver_cfg);
         else if (hdr_cnt >= 2 && b != 8'h00) csum_nz = 1'b1;
         hdr_cnt++;
      end else if (err == ST_OK && !ver_bad) begin
         off = obj_off;
         if (off < OBJ_HDR) begin
            case (off[1:0])
               2'd0: obj_len = {b, 8'h00};
               2'd1: obj_len = obj_len | {8'h00, b};
               2'd2: cur_class = b;
               default: cur_ctype = b;
            endcase
            obj_off = off + 16'd1;
            if (off == 16'd3) begin
               word_cnt = '0;
               if (obj_len < OBJ_HDR) err = ST_SHORT;
               else if (obj_len == OBJ_HDR) obj_off = '0;
            end
         end else begin
            shreg = {shreg[23:0], b};
            obj_off = off + 16'd1;
            if (obj_len[1:0] == 2'd0 && off[1:0] == 2'd3) begin
               mpls = (cur_class == class_cfg) && (cur_ctype == ctype_cfg);
               rec = '0;
               rec.kind       = KIND_WORD;
               rec.obj_class  = cur_class;
               rec.obj_ctype  = cur_ctype;
               rec.word_index = word_cnt;
               rec.word_value = shreg;
               rec.is_mpls    = mpls;
               if (mpls) begin
                  rec.label       = shreg[31:12];
                  rec.exp_bits    = shreg[11:9];
                  rec.bottom_flag = shreg[8];
                  rec.ttl         = shreg[7:0];
               end
               expected_records.push_back(rec);
               word_cnt++;
            end
            if (obj_off == obj_len) begin
               if (obj_len[1:0] != 2'd0) begin
                  err = ST_UNALIGNED;
               end else begin
                  obj_off = '0;
                  word_cnt = '0;
               end
            end
         end
      end

      if (lb) begin
         s = csum;
         if (hold[8]) s = fold16({16'h0, s} + {16'h0, hold[7:0], 8'h00});
         if (ver_bad) st = ST_VERSION;
         else if (csum_nz && s != CSUM_GOOD) st = ST_CHECKSUM;
         else if (err != ST_OK) st = err;
         else if (hdr_cnt < HDR_BYTES) st = ST_OVERRUN;
         else if (obj_off == 16'd0) st = ST_OK;
         else if (obj_off < OBJ_HDR) st = ST_TRAILING;
         else st = ST_OVERRUN;
         rec = '0;
         rec.kind   = KIND_STATUS;
         rec.status = st;
         rec.last   = 1'b1;
         expected_records.push_back(rec);
         clear_parse();
      end
   endtask

   task automatic compare_record(input rsp_type got);
      rsp_type want;
      if (expected_records.size() == 0) begin
         report("record with nothing expected, kind", 32'(got.kind), 32'h0);
      end else begin
         want = expected_records.pop_front();
         if (got.kind !== want.kind) report("kind", 32'(got.kind), 32'(want.kind));
         if (got.obj_class !== want.obj_class)
            report("obj_class", 32'(got.obj_class), 32'(want.obj_class));
         if (got.obj_ctype !== want.obj_ctype)
            report("obj_ctype", 32'(got.obj_ctype), 32'(want.obj_ctype));
         if (got.word_index !== want.word_index)
            report("word_index", 32'(got.word_index), 32'(want.word_index));
         if (got.word_value !== want.word_value)
            report("word_value", got.word_value, want.word_value);
         if (got.is_mpls !== want.is_mpls)
            report("is_mpls", 32'(got.is_mpls), 32'(want.is_mpls));
         if (got.label !== want.label) report("label", 32'(got.label), 32'(want.label));
         if (got.exp_bits !== want.exp_bits)
            report("exp_bits", 32'(got.exp_bits), 32'(want.exp_bits));
         if (got.bottom_flag !== want.bottom_flag)
            report("bottom_flag", 32'(got.bottom_flag), 32'(want.bottom_flag));
         if (got.ttl !== want.ttl) report("ttl", 32'(got.ttl), 32'(want.ttl));
         if (got.status !== want.status)
            report("status", 32'(got.status), 32'(want.status));
         if (got.last !== want.last) report("last", 32'(got.last), 32'(want.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         ver_cfg   = VERSION_RST;
         class_cfg = CLASS_RST;
         ctype_cfg = CTYPE_RST;
         clear_parse();
         expected_records.delete();
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[icmpx_pkg::CSR_ADDR_W-1:2])
               REG_VERSION: ver_cfg = csr_pwdata[3:0];
               REG_CLASS:   class_cfg = csr_pwdata[7:0];
               REG_CTYPE:   ctype_cfg = csr_pwdata[7:0];
               default: ;
            endcase
         end
         // request first, in case a record could leave in the cycle it was made
         if (req_valid && !req_stall) parse_byte(req_data.data_byte, req_data.last_byte);
         if (rsp_valid && !rsp_stall) compare_record(rsp_data);
      end
      pending_count = expected_records.size();
   end

endmodule

[verif/tb_top.sv]
// testbench top for icmp_extension_mpls_parser_top: clock, reset, csr writes,
// byte stimulus of extension areas and the receiver's stalls; verdict at the end
// depends on icmpx_pkg, icmp_extension_mpls_parser_top and icmpx_record_checker
`timescale 1ns / 1ps

module tb_top;
   import icmpx_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int ITEMS_PER_PHASE = 296;
   localparam int NUM_PHASES      = 6;
   localparam int LONG_HOLD       = 400;
   localparam int DRAIN_CYCLES    = 20;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   int          fail_count;
   int          pending_count;
   int          cycles;
   int          bytes_sent;
   int          req_idle_pct;
   int          rsp_idle_pct;
   logic        hold_request;
   logic [3:0]  cfg_ver;
   logic [7:0]  cfg_class;
   logic [7:0]  cfg_ctype;
   logic [7:0]  area_bytes[$];

   icmp_extension_mpls_parser_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   icmpx_record_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // receiver side: random stalls, plus one long hold-off when asked
   initial begin
      int   hold_left;
      logic hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(99);
      if (r < 10) return 8'h00;
      else if (r < 20) return 8'hff;
      return 8'($urandom);
   endfunction

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // header bytes 2..3 get the value that makes the area sum fold to all ones
   task automatic fill_checksum();
      logic [31:0] acc;
      logic [15:0] w;
      int i;
      acc = '0;
      area_bytes[2] = 8'h00;
      area_bytes[3] = 8'h00;
      for (i = 0; i < area_bytes.size(); i += 2) begin
         w = {area_bytes[i], (i + 1 < area_bytes.size()) ? area_bytes[i+1] : 8'h00};
         acc = acc + {16'h0, w};
         acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
      end
      area_bytes[2] = ~acc[15:8];
      area_bytes[3] = ~acc[7:0];
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input logic [7:0] b, input logic lb);
      req_type t;
      t.data_byte = b;
      t.last_byte = lb;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_area();
      int i;
      for (i = 0; i < area_bytes.size(); i++)
         send_item(area_bytes[i], i == area_bytes.size() - 1);
   endtask

   // mostly well-formed areas with random content, some broken or plain noise
   task automatic build_area();
      int          sel;
      int          n_obj;
      int          nw;
      int          n_data;
      int          i;
      int          j;
      int          cut;
      logic [15:0] len;
      logic [7:0]  cls;
      logic [7:0]  cty;
      area_bytes.delete();
      if ($urandom_range(99) < 6) begin
         repeat ($urandom_range(1, 8)) area_bytes.push_back(pick_byte());
      end else begin
         area_bytes.push_back({($urandom_range(99) < 90) ? cfg_ver : 4'($urandom),
                               4'($urandom)});
         area_bytes.push_back(pick_byte());
         area_bytes.push_back(8'h00);
         area_bytes.push_back(8'h00);
         n_obj = $urandom_range(0, 3);
         for (i = 0; i < n_obj; i++) begin
            nw = ($urandom_range(99) < 10) ? $urandom_range(4, 10) : $urandom_range(0, 3);
            len = 16'(4 + 4 * nw);
            n_data = 4 * nw;
            sel = $urandom_range(99);
            if (sel < 4) begin
               len = 16'($urandom_range(0, 3));
               n_data = 0;
            end else if (sel < 10) begin
               j = $urandom_range(1, 3);
               len = len + 16'(j);
               n_data = n_data + j;
            end else if (sel < 13) begin
               // random length, mostly far beyond the data, so the area often ends inside the object
               len = 16'($urandom);
            end
            sel = $urandom_range(99);
            if (sel < 60) begin
               cls = cfg_class;
               cty = cfg_ctype;
            end else if (sel < 70) begin
               cls = cfg_class;
               cty = pick_byte();
            end else if (sel < 80) begin
               cls = pick_byte();
               cty = cfg_ctype;
            end else begin
               cls = pick_byte();
               cty = pick_byte();
            end
            area_bytes.push_back(len[15:8]);
            area_bytes.push_back(len[7:0]);
            area_bytes.push_back(cls);
            area_bytes.push_back(cty);
            repeat (n_data) area_bytes.push_back(pick_byte());
         end
         if ($urandom_range(99) < 70) fill_checksum();
         sel = $urandom_range(99);
         if (sel < 8) begin
            cut = $urandom_range(1, area_bytes.size());
            while (area_bytes.size() > cut) void'(area_bytes.pop_back());
         end else if (sel < 14) begin
            repeat ($urandom_range(1, 3)) area_bytes.push_back(pick_byte());
         end else if (sel < 18) begin
            j = $urandom_range(0, area_bytes.size() - 1);
            area_bytes[j] = area_bytes[j] ^ 8'($urandom_range(1, 255));
         end
      end
   endtask

   initial begin
      int phase;
      int target;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      hold_request = 1'b0;
      bytes_sent = 0;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         // registers change only with the block drained
         while (pending_count != 0) @(negedge clock);
         repeat (8) @(negedge clock);
         case (phase)
            0: begin cfg_ver = VERSION_RST; cfg_class = CLASS_RST; cfg_ctype = CTYPE_RST; end
            1: begin cfg_ver = 4'h0; cfg_class = 8'h00; cfg_ctype = 8'h00; end
            2: begin cfg_ver = 4'hf; cfg_class = 8'hff; cfg_ctype = 8'hff; end
            default: begin
               cfg_ver = 4'($urandom);
               cfg_class = pick_byte();
               cfg_ctype = pick_byte();
            end
         endcase
         write_csr(REG_VERSION, ($urandom << 4) | {28'h0, cfg_ver});
         write_csr(REG_CLASS, ($urandom << 8) | {24'h0, cfg_class});
         write_csr(REG_CTYPE, ($urandom << 8) | {24'h0, cfg_ctype});

         case (phase / 2)
            0: begin req_idle_pct = 10; rsp_idle_pct = 53; end
            1: begin req_idle_pct = 53; rsp_idle_pct = 10; end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         if (phase == 4) hold_request = 1'b1;

         if (phase == 0) begin
            // good area, one mpls object holding an all-ones word
            area_bytes = '{8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h01, 8'h01,
                           8'hff, 8'hff, 8'hff, 8'hff};
            fill_checksum();
            send_area();
            // lone byte with the wrong version
            area_bytes = '{8'hf0};
            send_area();
            // object length below the object header
            area_bytes = '{8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h01, 8'h01};
            send_area();
            // header only, checksum field nonzero and wrong
            area_bytes = '{8'h20, 8'h00, 8'h12, 8'h34};
            send_area();
         end

         target = bytes_sent + ITEMS_PER_PHASE;
         while (bytes_sent < target) begin
            build_area();
            send_area();
         end
         req_valid <= 1'b0;
      end

      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
